// File: rtl/stride_value_predictor_macros.svh
// Assertion helpers used by svp_back; the enclosing module must provide clk and rst.
`ifndef STRIDE_VALUE_PREDICTOR_MACROS_SVH
`define STRIDE_VALUE_PREDICTOR_MACROS_SVH

// Same-cycle implication
`define SVP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stride value predictor check failed");

// Next-cycle implication
`define SVP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stride value predictor check failed");

`endif

// File: rtl/svp_pkg.sv
`timescale 1ns / 1ps
package svp_pkg;

  localparam int TABLE_ENTRIES    = 1024;  // power of two
  localparam int INFLIGHT_ENTRIES = 256;   // power of two
  localparam int TIDX_W = $clog2(TABLE_ENTRIES);
  localparam int FIDX_W = $clog2(INFLIGHT_ENTRIES);
  localparam int CLR_LEN = (TABLE_ENTRIES > INFLIGHT_ENTRIES) ? TABLE_ENTRIES
                                                               : INFLIGHT_ENTRIES;
  localparam int CLR_W = $clog2(CLR_LEN);
  localparam int QUEUE_DEPTH = 2;          // power of two
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [63:0] NO_VALUE = 64'hdeadbeef;
  localparam int FOLD_SHIFT = 8;

  localparam logic [1:0] CMD_FETCH  = 2'd0;
  localparam logic [1:0] CMD_EXEC   = 2'd1;
  localparam logic [1:0] CMD_RETIRE = 2'd2;

  localparam logic [3:0] CLS_ALU      = 4'd0;
  localparam logic [3:0] CLS_LOAD     = 4'd1;
  localparam logic [3:0] CLS_SLOW_ALU = 4'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] seq_no;
    logic [63:0] pc;
    logic        eligible;
    logic [3:0]  inst_class;
    logic        prediction_correct;
    logic [63:0] retired_value;
  } in_t;

  typedef struct packed {
    logic        predict_hit;
    logic [63:0] prediction;
  } out_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [63:0]       seq_no;
    logic [63:0]       pc;
    logic [TIDX_W-1:0] tslot;
    logic [FIDX_W-1:0] fidx;
    logic              predictable;
    logic              correct;
    logic [63:0]       actual;
  } job_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] tag;
    logic [63:0] last_value;
    logic [63:0] stride;
  } tbl_t;

  typedef struct packed {
    logic        occupied;
    logic [63:0] seq;
    logic [63:0] pc;
    logic        predictable;
    logic        spec_done;
  } flt_t;

  localparam int TBL_W = $bits(tbl_t);
  localparam int FLT_W = $bits(flt_t);

  function automatic logic [TIDX_W-1:0] slot_of(input logic [63:0] pc);
    logic [63:0] folded;
    folded = pc ^ (pc >> FOLD_SHIFT);
    return folded[TIDX_W-1:0];
  endfunction

endpackage

// File: rtl/stride_value_predictor.sv
// Each command passes through the queue, the registered table read and the result register.
// The back end pops a command only when idle; fetch, execute and unused commands then use the
// lookup state, and a retire that trains adds a training state for the second table read.
// Reset: synchronous; mode returns to 1, then a clearing pass over all 1024 table entries wipes
// the table valid bits and in-flight records while in_ready stays low.
`timescale 1ns / 1ps
module stride_value_predictor (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  svp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output svp_pkg::out_t out_data
);

  // Prediction mode: 0 last value, 1 last value plus stride.
  logic          mode;
  logic          clearing;
  logic          push_valid, push_ready;
  svp_pkg::job_t push_job;
  logic          q_valid, q_ready;
  svp_pkg::job_t q_job;

  // Hold mode until software writes it; writes must land only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // Front: classify each transfer and fold the pc into a table slot.
  svp_front u_front (
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .clearing(clearing),
    .push_valid(push_valid), .push_ready(push_ready), .push_job(push_job)
  );

  // Decouple the front from the table sequencer.
  svp_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_job(push_job),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_job(q_job)
  );

  // Back: table and in-flight lookups, speculative update, training, result register.
  svp_back u_back (
    .clk(clk), .rst(rst), .mode(mode),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
    .clearing(clearing),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

// File: rtl/svp_ram.sv
`timescale 1ns / 1ps
module svp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/svp_front.sv
`timescale 1ns / 1ps
module svp_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  svp_pkg::in_t  in_data,
  input  logic          clearing,
  output logic          push_valid,
  input  logic          push_ready,
  output svp_pkg::job_t push_job
);

  logic cls_ok;

  // Accept nothing while the tables are being wiped.
  assign in_ready   = push_ready && !clearing;
  assign push_valid = in_valid && !clearing;

  assign cls_ok = (in_data.inst_class == svp_pkg::CLS_ALU)
               || (in_data.inst_class == svp_pkg::CLS_LOAD)
               || (in_data.inst_class == svp_pkg::CLS_SLOW_ALU);

  always_comb begin
    push_job.cmd         = in_data.cmd;
    push_job.seq_no      = in_data.seq_no;
    push_job.pc          = in_data.pc;
    push_job.tslot       = svp_pkg::slot_of(in_data.pc);
    push_job.fidx        = in_data.seq_no[svp_pkg::FIDX_W-1:0];
    push_job.predictable = in_data.eligible && cls_ok;
    push_job.correct     = in_data.prediction_correct;
    push_job.actual      = in_data.retired_value;
  end

endmodule

// File: rtl/svp_queue.sv
`timescale 1ns / 1ps
module svp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  svp_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output svp_pkg::job_t pop_job
);

  svp_pkg::job_t             slots [svp_pkg::QUEUE_DEPTH];
  logic [svp_pkg::QPTR_W-1:0] wr_ptr;
  logic [svp_pkg::QPTR_W-1:0] rd_ptr;
  logic [svp_pkg::QPTR_W:0]   count;
  logic                       do_push;
  logic                       do_pop;

  assign push_ready = (count != (svp_pkg::QPTR_W + 1)'(svp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/svp_back.sv
`timescale 1ns / 1ps
`include "stride_value_predictor_macros.svh"
module svp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          mode,
  input  logic          q_valid,
  output logic          q_ready,
  input  svp_pkg::job_t q_job,
  output logic          clearing,
  output logic          out_valid,
  input  logic          out_ready,
  output svp_pkg::out_t out_data
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_TRAIN = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [svp_pkg::CLR_W-1:0]  clr_idx;
  svp_pkg::job_t              job;
  logic [63:0]                rpc;
  logic [svp_pkg::TIDX_W-1:0] rslot;
  logic [63:0]                held_prediction;
  logic                       held_did_predict;

  logic                       tbl_we, tbl_re;
  logic [svp_pkg::TIDX_W-1:0] tbl_waddr, tbl_raddr;
  svp_pkg::tbl_t              tbl_wdata, tbl_q;
  logic                       flt_we, flt_re;
  logic [svp_pkg::FIDX_W-1:0] flt_waddr, flt_raddr;
  svp_pkg::flt_t              flt_wdata, flt_q;

  logic                       out_free;
  logic                       res_load;
  svp_pkg::out_t              res;
  logic                       tbl_hit, flt_hit, spec, train, train_hit;
  logic [63:0]                pred_val;
  logic [svp_pkg::TIDX_W-1:0] flt_slot;
  logic                       clr_tbl, clr_flt;

  svp_ram #(.WIDTH(svp_pkg::TBL_W), .DEPTH(svp_pkg::TABLE_ENTRIES)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_q)
  );

  svp_ram #(.WIDTH(svp_pkg::FLT_W), .DEPTH(svp_pkg::INFLIGHT_ENTRIES)) u_flt (
    .clk(clk), .we(flt_we), .waddr(flt_waddr), .wdata(flt_wdata),
    .re(flt_re), .raddr(flt_raddr), .rdata(flt_q)
  );

  assign clearing = (state == S_CLEAR);
  assign out_free = !out_valid || out_ready;

  assign clr_tbl = ({1'b0, clr_idx} < (svp_pkg::CLR_W + 1)'(svp_pkg::TABLE_ENTRIES));
  assign clr_flt = ({1'b0, clr_idx} < (svp_pkg::CLR_W + 1)'(svp_pkg::INFLIGHT_ENTRIES));

  assign tbl_hit   = tbl_q.valid && (tbl_q.tag == job.pc);
  assign pred_val  = mode ? (tbl_q.last_value + tbl_q.stride) : tbl_q.last_value;
  assign spec      = job.predictable && held_did_predict && job.correct && tbl_hit;
  assign flt_hit   = flt_q.occupied && (flt_q.seq == job.seq_no);
  assign train     = flt_hit && flt_q.predictable && (job.actual != svp_pkg::NO_VALUE)
                  && !flt_q.spec_done;
  assign flt_slot  = svp_pkg::slot_of(flt_q.pc);
  assign train_hit = tbl_q.valid && (tbl_q.tag == rpc);

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    tbl_re     = 1'b0;
    tbl_raddr  = q_job.tslot;
    flt_re     = 1'b0;
    flt_raddr  = q_job.fidx;
    tbl_we     = 1'b0;
    tbl_waddr  = job.tslot;
    tbl_wdata  = '0;
    flt_we     = 1'b0;
    flt_waddr  = job.fidx;
    flt_wdata  = '0;
    res_load   = 1'b0;
    res        = '0;
    case (state)
      S_CLEAR: begin
        tbl_we    = clr_tbl;
        tbl_waddr = clr_idx[svp_pkg::TIDX_W-1:0];
        flt_we    = clr_flt;
        flt_waddr = clr_idx[svp_pkg::FIDX_W-1:0];
        if (clr_idx == svp_pkg::CLR_W'(svp_pkg::CLR_LEN - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          tbl_re     = 1'b1;
          flt_re     = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          case (job.cmd)
            svp_pkg::CMD_FETCH: begin
              if (tbl_hit) begin
                res.predict_hit = 1'b1;
                res.prediction  = pred_val;
              end
            end
            svp_pkg::CMD_EXEC: begin
              flt_we    = 1'b1;
              flt_wdata = '{occupied: 1'b1, seq: job.seq_no, pc: job.pc,
                            predictable: job.predictable, spec_done: spec};
              if (spec) begin
                tbl_we    = 1'b1;
                tbl_wdata = '{valid: tbl_q.valid, tag: tbl_q.tag,
                              last_value: held_prediction, stride: tbl_q.stride};
              end
            end
            svp_pkg::CMD_RETIRE: begin
              flt_we = flt_hit;
              if (train) begin
                tbl_re     = 1'b1;
                tbl_raddr  = flt_slot;
                state_next = S_TRAIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_TRAIN: begin
        tbl_we    = 1'b1;
        tbl_waddr = rslot;
        if (train_hit) begin
          tbl_wdata = '{valid: 1'b1, tag: tbl_q.tag, last_value: job.actual,
                        stride: job.actual - tbl_q.last_value};
        end else begin
          tbl_wdata = '{valid: 1'b1, tag: rpc, last_value: job.actual, stride: 64'd0};
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_idx          <= '0;
      held_prediction  <= '0;
      held_did_predict <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if ((state == S_LOOK) && out_free) begin
        if (job.cmd == svp_pkg::CMD_FETCH) begin
          held_did_predict <= tbl_hit;
          if (tbl_hit) begin
            held_prediction <= pred_val;
          end
        end else if (job.cmd == svp_pkg::CMD_EXEC) begin
          held_did_predict <= 1'b0;
        end
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      job <= q_job;
    end
    if (state == S_LOOK) begin
      rpc   <= flt_q.pc;
      rslot <= flt_slot;
    end
    if (res_load) begin
      out_data <= res;
    end
  end

  `SVP_ASSERT_NOW(a_pop_only_idle, q_valid && q_ready, state == S_IDLE)
  `SVP_ASSERT_NEXT(a_train_one_cycle, state == S_TRAIN, state == S_IDLE)
  `SVP_ASSERT_NEXT(a_look_gives_result, (state == S_LOOK) && out_free, out_valid)
  `SVP_ASSERT_NOW(a_miss_is_zero, out_valid && !out_data.predict_hit,
                  out_data.prediction == 64'd0)

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int TBL_N  = 1024;
  localparam int FLT_N  = 256;
  localparam int POOL_N = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  svp_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  svp_pkg::out_t out_data;

  stride_value_predictor i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the predictor state.
  logic        pm_mode;
  logic        tv_valid [TBL_N];
  logic [63:0] tv_tag   [TBL_N];
  logic [63:0] tv_last  [TBL_N];
  logic [63:0] tv_stride[TBL_N];
  logic        fl_occ   [FLT_N];
  logic [63:0] fl_seq   [FLT_N];
  logic [63:0] fl_pc    [FLT_N];
  logic        fl_pred  [FLT_N];
  logic        fl_spec  [FLT_N];
  logic [63:0] hold_value;
  logic        hold_hit;

  svp_pkg::out_t pending_results[$];
  int   mismatches = 0;
  bit   long_hold_req = 1'b0;

  function automatic logic [9:0] table_slot(logic [63:0] pc);
    logic [63:0] f;
    f = pc ^ (pc >> 8);
    return f[9:0];
  endfunction

  // Advance the shadow state by one transfer and return what the block must answer.
  function automatic svp_pkg::out_t predict_value(svp_pkg::in_t x);
    svp_pkg::out_t r;
    logic [9:0]  s;
    logic [7:0]  fi;
    logic        pred;
    logic        spec;
    r = '0;
    fi = x.seq_no[7:0];
    case (x.cmd)
      svp_pkg::CMD_FETCH: begin
        s = table_slot(x.pc);
        if (tv_valid[s] && tv_tag[s] == x.pc) begin
          r.predict_hit = 1'b1;
          r.prediction = pm_mode ? tv_last[s] + tv_stride[s] : tv_last[s];
          hold_value = r.prediction;
          hold_hit = 1'b1;
        end else begin
          hold_hit = 1'b0;
        end
      end
      svp_pkg::CMD_EXEC: begin
        pred = x.eligible && (x.inst_class == svp_pkg::CLS_ALU ||
                              x.inst_class == svp_pkg::CLS_LOAD ||
                              x.inst_class == svp_pkg::CLS_SLOW_ALU);
        spec = 1'b0;
        s = table_slot(x.pc);
        if (pred && hold_hit && x.prediction_correct && tv_valid[s] && tv_tag[s] == x.pc) begin
          tv_last[s] = hold_value;
          spec = 1'b1;
        end
        hold_hit = 1'b0;
        fl_occ[fi] = 1'b1;
        fl_seq[fi] = x.seq_no;
        fl_pc[fi] = x.pc;
        fl_pred[fi] = pred;
        fl_spec[fi] = spec;
      end
      svp_pkg::CMD_RETIRE: begin
        if (fl_occ[fi] && fl_seq[fi] == x.seq_no) begin
          fl_occ[fi] = 1'b0;
          if (fl_pred[fi] && x.retired_value != svp_pkg::NO_VALUE && !fl_spec[fi]) begin
            s = table_slot(fl_pc[fi]);
            if (tv_valid[s] && tv_tag[s] == fl_pc[fi]) begin
              tv_stride[s] = x.retired_value - tv_last[s];
              tv_last[s] = x.retired_value;
            end else begin
              tv_tag[s] = fl_pc[fi];
              tv_last[s] = x.retired_value;
              tv_stride[s] = '0;
              tv_valid[s] = 1'b1;
            end
          end
        end
      end
      default: ;  // unused command: no state change
    endcase
    return r;
  endfunction

  // Sender burst state: a burst of back-to-back transfers, then a random gap.
  int burst_left = 0;

  task automatic send_item(svp_pkg::in_t x, bit typed, svp_pkg::out_t typed_res);
    svp_pkg::out_t r;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    r = predict_value(x);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic drain_and_set_mode(logic m);
    drop_valid();
    wait (pending_results.size() == 0);
    repeat (5) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    pm_mode = m;
  endtask

  function automatic svp_pkg::in_t make_item(logic [1:0] c, logic [63:0] sq, logic [63:0] pc,
                                             logic el, logic [3:0] cl, logic ok,
                                             logic [63:0] av);
    svp_pkg::in_t x;
    x.cmd = c;
    x.seq_no = sq;
    x.pc = pc;
    x.eligible = el;
    x.inst_class = cl;
    x.prediction_correct = ok;
    x.retired_value = av;
    return x;
  endfunction

  // Directed stimulus: a fixed walk through allocate, train, speculate and the corner cases.
  typedef struct {
    svp_pkg::in_t  item;
    bit            typed;
    svp_pkg::out_t res;
  } step_row_t;

  localparam logic [63:0] ONES = '1;
  localparam logic [63:0] PCA  = 64'h0000_0000_0000_1000;

  step_row_t steps[$];

  task automatic add_row(svp_pkg::in_t x, bit typed, logic h, logic [63:0] v);
    step_row_t row;
    row.item = x;
    row.typed = typed;
    row.res.predict_hit = h;
    row.res.prediction = v;
    steps.push_back(row);
  endtask

  task automatic build_steps();
    // cold table: every fetch misses
    add_row(make_item(svp_pkg::CMD_FETCH, 0, 0, 0, 0, 0, 0), 1, 0, 0);
    add_row(make_item(svp_pkg::CMD_FETCH, ONES, ONES, 1, 4'hf, 1, ONES), 1, 0, 0);
    // allocate PCA with value 5, stride 0
    add_row(make_item(svp_pkg::CMD_EXEC, 0, PCA, 1, svp_pkg::CLS_ALU, 0, 0), 1, 0, 0);
    add_row(make_item(svp_pkg::CMD_RETIRE, 0, 0, 0, 0, 0, 5), 1, 0, 0);
    add_row(make_item(svp_pkg::CMD_FETCH, 7, PCA, 0, 0, 0, 0), 1, 1, 5);
    // train: stride becomes 7
    add_row(make_item(svp_pkg::CMD_EXEC, 1, PCA, 1, svp_pkg::CLS_LOAD, 0, 0), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_RETIRE, 1, 0, 0, 0, 0, 12), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_FETCH, 0, PCA, 0, 0, 0, 0), 1, 1, 19);
    // correct prediction writes back speculatively; its retire then leaves the table alone
    add_row(make_item(svp_pkg::CMD_EXEC, 2, PCA, 1, svp_pkg::CLS_SLOW_ALU, 1, 0), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_RETIRE, 2, 0, 0, 0, 0, 100), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_FETCH, 0, PCA, 0, 0, 0, 0), 1, 1, 26);
    // no-value retire, a non-predictable class and an ineligible item leave the table alone
    add_row(make_item(svp_pkg::CMD_EXEC, 3, PCA, 1, svp_pkg::CLS_ALU, 0, 0), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_RETIRE, 3, 0, 0, 0, 0, svp_pkg::NO_VALUE), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_EXEC, 4, PCA, 1, 4'd8, 0, 0), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_RETIRE, 4, 0, 0, 0, 0, 1), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_EXEC, 5, PCA, 0, svp_pkg::CLS_ALU, 0, 0), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_RETIRE, 5, 0, 0, 0, 0, 1), 0, 0, 0);
    // unused command is answered with zero
    add_row(make_item(CMD_UNUSED, ONES, ONES, 1, 4'hf, 1, ONES), 1, 0, 0);
    // in-flight collision: seq 256 evicts seq 0, so the retire of 0 finds nothing
    add_row(make_item(svp_pkg::CMD_EXEC, 0, ONES, 1, svp_pkg::CLS_ALU, 0, 0), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_EXEC, 256, ONES, 1, svp_pkg::CLS_ALU, 0, 0), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_RETIRE, 0, 0, 0, 0, 0, 9), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_RETIRE, 256, 0, 0, 0, 0, ONES), 0, 0, 0);
    add_row(make_item(svp_pkg::CMD_FETCH, 0, ONES, 0, 0, 0, 0), 1, 1, ONES);
    // retire with no record at all
    add_row(make_item(svp_pkg::CMD_RETIRE, ONES, 0, 0, 0, 0, 3), 1, 0, 0);
  endtask

  // Random part: well-formed fetch/execute/retire flows over a small pc pool, plus noise.
  logic [63:0] pool_pc [POOL_N];
  logic [63:0] pool_val[POOL_N];
  logic [63:0] pool_str[POOL_N];
  logic [63:0] inflight_seq[$];
  logic [63:0] next_seq;

  task automatic retire_one();
    int k;
    int p;
    logic [63:0] av;
    k = $urandom_range(0, inflight_seq.size() - 1);
    p = $urandom_range(0, POOL_N - 1);
    pool_val[p] += pool_str[p];
    av = ($urandom_range(0, 15) == 0) ? svp_pkg::NO_VALUE : pool_val[p];
    send_item(make_item(svp_pkg::CMD_RETIRE, inflight_seq[k], {$urandom, $urandom}, $urandom,
                        $urandom, $urandom, av), 0, '0);
    inflight_seq.delete(k);
  endtask

  task automatic random_phase(int n);
    int sent;
    int p;
    logic [3:0] cl;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 7) begin
        p = $urandom_range(0, POOL_N - 1);
        case ($urandom_range(0, 3))
          0: cl = svp_pkg::CLS_ALU;
          1: cl = svp_pkg::CLS_LOAD;
          2: cl = svp_pkg::CLS_SLOW_ALU;
          default: cl = $urandom;
        endcase
        send_item(make_item(svp_pkg::CMD_FETCH, {$urandom, $urandom}, pool_pc[p], $urandom,
                            $urandom, $urandom, {$urandom, $urandom}), 0, '0);
        send_item(make_item(svp_pkg::CMD_EXEC, next_seq, pool_pc[p],
                            $urandom_range(0, 7) != 0, cl,
                            $urandom, {$urandom, $urandom}), 0, '0);
        inflight_seq.push_back(next_seq);
        next_seq++;
        sent += 2;
        while (inflight_seq.size() > 6 || (inflight_seq.size() > 0 && $urandom_range(0, 1))) begin
          retire_one();
          sent++;
        end
      end else begin
        send_item(make_item($urandom, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                            $urandom, $urandom, {$urandom, $urandom}), 0, '0);
        sent++;
      end
    end
  endtask

  // Receiver: stall on its own pattern; on request, hold off for a long stretch.
  initial begin
    int n;
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        n = $urandom_range(1, 30);
        case ($urandom_range(0, 3))
          0: begin
            out_ready <= 1'b1;
            repeat (n) @(posedge clk);
          end
          1: begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
          end
          default: begin
            repeat (n) begin
              out_ready <= $urandom_range(0, 2) != 0;
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  // Result checker: compare each transfer against the oldest expectation.
  always @(posedge clk) begin
    svp_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result hit=%0b value=%h",
                   out_data.predict_hit, out_data.prediction);
      end else begin
        want = pending_results.pop_front();
        if (out_data.predict_hit !== want.predict_hit ||
            out_data.prediction !== want.prediction) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b value=%h, got hit=%0b value=%h",
                     want.predict_hit, want.prediction,
                     out_data.predict_hit, out_data.prediction);
        end
      end
    end
  end

  // Watchdog: covers the clearing pass, the long hold-off and the slowest stall pattern.
  initial begin
    #5ms;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    pm_mode = 1'b1;
    hold_value = '0;
    hold_hit = 1'b0;
    for (int i = 0; i < TBL_N; i++) tv_valid[i] = 1'b0;
    for (int i = 0; i < FLT_N; i++) fl_occ[i] = 1'b0;
    for (int i = 0; i < POOL_N; i++) begin
      // odd entries alias the slot of the entry before them with a different tag
      pool_pc[i] = (i % 2) ? pool_pc[i-1] ^ 64'h0010_0000 : {$urandom, $urandom};
      pool_val[i] = {$urandom, $urandom};
      pool_str[i] = (i % 4 == 0) ? {$urandom, $urandom} : $urandom_range(0, 16);
    end
    next_seq = {$urandom, 32'h0};
    build_steps();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    drain_and_set_mode(1'b1);
    foreach (steps[i]) send_item(steps[i].item, steps[i].typed, steps[i].res);

    drain_and_set_mode(1'b0);
    random_phase(200);

    // Fill the block while the receiver holds off.
    long_hold_req = 1'b1;
    burst_left = 1000;
    random_phase(40);
    burst_left = 0;

    drain_and_set_mode(1'b1);
    random_phase(220);

    // Pause until every result is back, then carry on.
    drop_valid();
    wait (pending_results.size() == 0);

    drain_and_set_mode(1'b0);
    random_phase(100);
    drain_and_set_mode(1'b1);
    random_phase(100);
    while (inflight_seq.size() > 0) retire_one();

    drop_valid();
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
